/* rtl/core/mcc_pkg.sv */
`timescale 1ns / 1ps
// Package for the minicomputer ALU and condition-code block.
// Holds operation codes, flag and transfer payload types; no dependencies.
package mcc_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned ModeW = 6;
  localparam int unsigned OffW  = 8;

  localparam logic [WordW-1:0] SIGN_MASK = 16'h8000;
  localparam logic [WordW-1:0] MAX_POS   = 16'h7fff;
  localparam logic [WordW-1:0] ALL_ONES  = 16'hffff;

  localparam logic [ModeW-1:0] OP_MOV  = 6'd0;
  localparam logic [ModeW-1:0] OP_CMP  = 6'd1;
  localparam logic [ModeW-1:0] OP_BIT  = 6'd2;
  localparam logic [ModeW-1:0] OP_BIC  = 6'd3;
  localparam logic [ModeW-1:0] OP_BIS  = 6'd4;
  localparam logic [ModeW-1:0] OP_ADD  = 6'd5;
  localparam logic [ModeW-1:0] OP_SUB  = 6'd6;
  localparam logic [ModeW-1:0] OP_CLR  = 6'd7;
  localparam logic [ModeW-1:0] OP_COM  = 6'd8;
  localparam logic [ModeW-1:0] OP_INC  = 6'd9;
  localparam logic [ModeW-1:0] OP_DEC  = 6'd10;
  localparam logic [ModeW-1:0] OP_NEG  = 6'd11;
  localparam logic [ModeW-1:0] OP_ADC  = 6'd12;
  localparam logic [ModeW-1:0] OP_TST  = 6'd13;
  localparam logic [ModeW-1:0] OP_ROR  = 6'd14;
  localparam logic [ModeW-1:0] OP_ROL  = 6'd15;
  localparam logic [ModeW-1:0] OP_ASR  = 6'd16;
  localparam logic [ModeW-1:0] OP_ASL  = 6'd17;
  localparam logic [ModeW-1:0] OP_SWAB = 6'd18;
  localparam logic [ModeW-1:0] OP_BR   = 6'd19;
  localparam logic [ModeW-1:0] OP_BNE  = 6'd20;
  localparam logic [ModeW-1:0] OP_BEQ  = 6'd21;
  localparam logic [ModeW-1:0] OP_BGE  = 6'd22;
  localparam logic [ModeW-1:0] OP_BLT  = 6'd23;
  localparam logic [ModeW-1:0] OP_BGT  = 6'd24;
  localparam logic [ModeW-1:0] OP_BLE  = 6'd25;
  localparam logic [ModeW-1:0] OP_BPL  = 6'd26;
  localparam logic [ModeW-1:0] OP_BMI  = 6'd27;
  localparam logic [ModeW-1:0] OP_BHI  = 6'd28;
  localparam logic [ModeW-1:0] OP_BLOS = 6'd29;
  localparam logic [ModeW-1:0] OP_BVC  = 6'd30;
  localparam logic [ModeW-1:0] OP_BVS  = 6'd31;
  localparam logic [ModeW-1:0] OP_BCC  = 6'd32;
  localparam logic [ModeW-1:0] OP_BCS  = 6'd33;

  typedef struct packed {
    logic n;
    logic z;
    logic v;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [ModeW-1:0]       mode;
    logic [WordW-1:0]       src_word;
    logic [WordW-1:0]       dst_word;
    logic [WordW-1:0]       pc_value;
    logic signed [OffW-1:0] br_disp;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] result_word;
    logic             write_back;
    logic             flag_n;
    logic             flag_z;
    logic             flag_v;
    logic             flag_c;
    logic             branch_taken;
    logic [WordW-1:0] next_pc;
  } out_item_t;

endpackage

/* rtl/core/mcc_alu.sv */
`timescale 1ns / 1ps
// Word ALU, flag rules and branch evaluation for one operation.
// Pure combinational; depends on mcc_pkg.
module mcc_alu (
  input  mcc_pkg::in_item_t  item,
  input  mcc_pkg::flags_t    flags_in,
  output mcc_pkg::out_item_t result,
  output mcc_pkg::flags_t    flags_out
);
  import mcc_pkg::*;

  logic [WordW-1:0] s, d, r;
  logic [WordW:0]   add_sum, sub_ds, sub_sd;
  logic [WordW-1:0] npc_taken;
  logic             wb, cond, is_branch;
  flags_t           f;

  assign s = item.src_word;
  assign d = item.dst_word;

  assign add_sum = {1'b0, d} + {1'b0, s};
  assign sub_ds  = {1'b0, d} - {1'b0, s};
  assign sub_sd  = {1'b0, s} - {1'b0, d};
  assign npc_taken = item.pc_value
                   + {{(WordW-OffW-1){item.br_disp[OffW-1]}}, item.br_disp, 1'b0};

  always_comb begin
    r         = '0;
    wb        = 1'b0;
    f         = flags_in;
    cond      = 1'b0;
    is_branch = 1'b0;
    unique case (item.mode)
      OP_MOV: begin
        r = s; wb = 1'b1;
        f = '{n: r[WordW-1], z: (r == '0), v: 1'b0, c: flags_in.c};
      end
      OP_CMP: begin
        r = sub_sd[WordW-1:0];
        f = '{n: r[WordW-1], z: (r == '0),
              v: ((s ^ d) & (s ^ r) & SIGN_MASK) != '0, c: sub_sd[WordW]};
      end
      OP_BIT: begin
        r = s & d;
        f = '{n: r[WordW-1], z: (r == '0), v: 1'b0, c: flags_in.c};
      end
      OP_BIC: begin
        r = d & ~s; wb = 1'b1;
        f = '{n: r[WordW-1], z: (r == '0), v: 1'b0, c: flags_in.c};
      end
      OP_BIS: begin
        r = d | s; wb = 1'b1;
        f = '{n: r[WordW-1], z: (r == '0), v: 1'b0, c: flags_in.c};
      end
      OP_ADD: begin
        r = add_sum[WordW-1:0]; wb = 1'b1;
        f = '{n: r[WordW-1], z: (r == '0),
              v: (~(s ^ d) & (s ^ r) & SIGN_MASK) != '0, c: add_sum[WordW]};
      end
      OP_SUB: begin
        r = sub_ds[WordW-1:0]; wb = 1'b1;
        f = '{n: r[WordW-1], z: (r == '0),
              v: ((s ^ d) & (d ^ r) & SIGN_MASK) != '0, c: sub_ds[WordW]};
      end
      OP_CLR: begin
        r = '0; wb = 1'b1;
        f = '{n: 1'b0, z: 1'b1, v: 1'b0, c: 1'b0};
      end
      OP_COM: begin
        r = ~d; wb = 1'b1;
        f = '{n: r[WordW-1], z: (r == '0), v: 1'b0, c: 1'b1};
      end
      OP_INC: begin
        r = d + WordW'(1); wb = 1'b1;
        f = '{n: r[WordW-1], z: (r == '0), v: (d == MAX_POS), c: flags_in.c};
      end
      OP_DEC: begin
        r = d - WordW'(1); wb = 1'b1;
        f = '{n: r[WordW-1], z: (r == '0), v: (d == SIGN_MASK), c: flags_in.c};
      end
      OP_NEG: begin
        r = '0 - d; wb = 1'b1;
        f = '{n: r[WordW-1], z: (r == '0), v: (r == SIGN_MASK), c: (r != '0)};
      end
      OP_ADC: begin
        r = d + WordW'(flags_in.c); wb = 1'b1;
        f = '{n: r[WordW-1], z: (r == '0), v: (d == MAX_POS) && flags_in.c,
              c: (d == ALL_ONES) && flags_in.c};
      end
      OP_TST: begin
        r = d;
        f = '{n: r[WordW-1], z: (r == '0), v: 1'b0, c: 1'b0};
      end
      OP_ROR: begin
        r = {flags_in.c, d[WordW-1:1]}; wb = 1'b1;
        f = '{n: r[WordW-1], z: (r == '0), v: r[WordW-1] ^ d[0], c: d[0]};
      end
      OP_ROL: begin
        r = {d[WordW-2:0], flags_in.c}; wb = 1'b1;
        f = '{n: r[WordW-1], z: (r == '0), v: r[WordW-1] ^ d[WordW-1], c: d[WordW-1]};
      end
      OP_ASR: begin
        r = {d[WordW-1], d[WordW-1:1]}; wb = 1'b1;
        f = '{n: r[WordW-1], z: (r == '0), v: r[WordW-1] ^ d[0], c: d[0]};
      end
      OP_ASL: begin
        r = {d[WordW-2:0], 1'b0}; wb = 1'b1;
        f = '{n: r[WordW-1], z: (r == '0), v: r[WordW-1] ^ d[WordW-1], c: d[WordW-1]};
      end
      OP_SWAB: begin
        r = {d[7:0], d[WordW-1:8]}; wb = 1'b1;
        f = '{n: r[7], z: (r[7:0] == 8'h00), v: 1'b0, c: 1'b0};
      end
      OP_BR:   begin is_branch = 1'b1; cond = 1'b1; end
      OP_BNE:  begin is_branch = 1'b1; cond = !flags_in.z; end
      OP_BEQ:  begin is_branch = 1'b1; cond = flags_in.z; end
      OP_BGE:  begin is_branch = 1'b1; cond = (flags_in.n == flags_in.v); end
      OP_BLT:  begin is_branch = 1'b1; cond = (flags_in.n != flags_in.v); end
      OP_BGT:  begin
        is_branch = 1'b1; cond = !(flags_in.z || (flags_in.n != flags_in.v));
      end
      OP_BLE:  begin
        is_branch = 1'b1; cond = flags_in.z || (flags_in.n != flags_in.v);
      end
      OP_BPL:  begin is_branch = 1'b1; cond = !flags_in.n; end
      OP_BMI:  begin is_branch = 1'b1; cond = flags_in.n; end
      OP_BHI:  begin is_branch = 1'b1; cond = !flags_in.c && !flags_in.z; end
      OP_BLOS: begin is_branch = 1'b1; cond = flags_in.c || flags_in.z; end
      OP_BVC:  begin is_branch = 1'b1; cond = !flags_in.v; end
      OP_BVS:  begin is_branch = 1'b1; cond = flags_in.v; end
      OP_BCC:  begin is_branch = 1'b1; cond = !flags_in.c; end
      OP_BCS:  begin is_branch = 1'b1; cond = flags_in.c; end
      default: begin
        r = '0;
      end
    endcase
  end

  assign flags_out = f;

  always_comb begin
    result.result_word  = r;
    result.write_back   = wb;
    result.flag_n       = f.n;
    result.flag_z       = f.z;
    result.flag_v       = f.v;
    result.flag_c       = f.c;
    result.branch_taken = is_branch && cond;
    result.next_pc      = (is_branch && cond) ? npc_taken : item.pc_value;
  end

endmodule

/* rtl/core/minicomputer_alu_condition_codes_top.sv */
`timescale 1ns / 1ps
// Top level of the minicomputer ALU and condition-code block.
// An accepted item passes the input register, then the result register, before its result is valid.
// Throughput: 1 item per cycle while out_stall is low; the flag register feeds back within one ALU pass.
// Reset: synchronous active-low rst_n clears both stage valids and all four flags.
// Depends on mcc_pkg and mcc_alu.
module minicomputer_alu_condition_codes_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mcc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mcc_pkg::out_item_t  out_data
);
  import mcc_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  flags_t    flags_r, flags_nxt;

  out_item_t alu_result;
  flags_t    alu_flags;
  logic      s2_ready, s1_adv, in_xfer;

  mcc_alu u_alu (
    .item      (s1_data_r),
    .flags_in  (flags_r),
    .result    (alu_result),
    .flags_out (alu_flags)
  );

  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    flags_nxt     = s1_adv ? alu_flags : flags_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      flags_r     <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= alu_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_flags_match : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (flags_r == {out_data_r.flag_n, out_data_r.flag_z,
                                 out_data_r.flag_v, out_data_r.flag_c}))
    else $error("held flags differ from flags of pending result");

  a_stall_needs_item : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free pipeline");

  a_branch_no_wb : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.branch_taken) |->
      (!out_data_r.write_back && out_data_r.result_word == '0))
    else $error("taken branch carries a write-back result");

  a_flags_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(flags_r))
    else $error("flags changed without an ALU pass");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for minicomputer_alu_condition_codes_top: drives operations with random
// idling on both channels, predicts result words, flags and branch targets, checks each result.
// Depends on mcc_pkg and the block's RTL.
module tb_top;
  import mcc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  out_item_t exp_results[$];
  flags_t    cc_model = '0;
  int        mismatch_count = 0;
  int        sent_count = 0;
  int        checked_count = 0;
  int        cycle_count = 0;
  bit        tx_gap_en = 1'b1;
  bit        rx_gap_en = 1'b1;
  int        rx_hold_left = 0;
  int        rx_burst_left = 0;

  minicomputer_alu_condition_codes_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic out_item_t alu_predict(in_item_t it, flags_t cc);
    out_item_t  r;
    flags_t     f;
    logic [15:0] s, d, w, x;
    logic [16:0] sum;
    logic        wb, take, cres;
    s    = it.src_word;
    d    = it.dst_word;
    w    = 16'h0;
    f    = cc;
    wb   = 1'b0;
    take = 1'b0;
    case (it.mode)
      OP_MOV: begin w = s; wb = 1'b1; f = {w[15], w == 16'h0, 1'b0, cc.c}; end
      OP_CMP: begin
        w = s - d;
        x = (s ^ d) & (s ^ w);
        f = {w[15], w == 16'h0, x[15], s < d};
      end
      OP_BIT: begin w = s & d; f = {w[15], w == 16'h0, 1'b0, cc.c}; end
      OP_BIC: begin w = d & ~s; wb = 1'b1; f = {w[15], w == 16'h0, 1'b0, cc.c}; end
      OP_BIS: begin w = d | s; wb = 1'b1; f = {w[15], w == 16'h0, 1'b0, cc.c}; end
      OP_ADD: begin
        sum = {1'b0, d} + {1'b0, s};
        w   = sum[15:0];
        wb  = 1'b1;
        x   = ~(s ^ d) & (s ^ w);
        f   = {w[15], w == 16'h0, x[15], sum[16]};
      end
      OP_SUB: begin
        w  = d - s;
        wb = 1'b1;
        x  = (s ^ d) & (d ^ w);
        f  = {w[15], w == 16'h0, x[15], d < s};
      end
      OP_CLR: begin w = 16'h0; wb = 1'b1; f = 4'b0100; end
      OP_COM: begin w = ~d; wb = 1'b1; f = {w[15], w == 16'h0, 1'b0, 1'b1}; end
      OP_INC: begin
        w  = d + 16'h1;
        wb = 1'b1;
        f  = {w[15], w == 16'h0, d == MAX_POS, cc.c};
      end
      OP_DEC: begin
        w  = d - 16'h1;
        wb = 1'b1;
        f  = {w[15], w == 16'h0, d == SIGN_MASK, cc.c};
      end
      OP_NEG: begin
        w  = 16'h0 - d;
        wb = 1'b1;
        f  = {w[15], w == 16'h0, w == SIGN_MASK, w != 16'h0};
      end
      OP_ADC: begin
        w  = d + {15'h0, cc.c};
        wb = 1'b1;
        f  = {w[15], w == 16'h0, (d == MAX_POS) && cc.c, (d == ALL_ONES) && cc.c};
      end
      OP_TST: begin w = d; f = {w[15], w == 16'h0, 2'b00}; end
      OP_ROR: begin
        w = {cc.c, d[15:1]}; cres = d[0]; wb = 1'b1;
        f = {w[15], w == 16'h0, w[15] ^ cres, cres};
      end
      OP_ROL: begin
        w = {d[14:0], cc.c}; cres = d[15]; wb = 1'b1;
        f = {w[15], w == 16'h0, w[15] ^ cres, cres};
      end
      OP_ASR: begin
        w = {d[15], d[15:1]}; cres = d[0]; wb = 1'b1;
        f = {w[15], w == 16'h0, w[15] ^ cres, cres};
      end
      OP_ASL: begin
        w = {d[14:0], 1'b0}; cres = d[15]; wb = 1'b1;
        f = {w[15], w == 16'h0, w[15] ^ cres, cres};
      end
      OP_SWAB: begin
        w = {d[7:0], d[15:8]}; wb = 1'b1;
        f = {w[7], w[7:0] == 8'h0, 2'b00};
      end
      OP_BR:   take = 1'b1;
      OP_BNE:  take = !cc.z;
      OP_BEQ:  take = cc.z;
      OP_BGE:  take = (cc.n == cc.v);
      OP_BLT:  take = (cc.n != cc.v);
      OP_BGT:  take = !(cc.z || (cc.n != cc.v));
      OP_BLE:  take = cc.z || (cc.n != cc.v);
      OP_BPL:  take = !cc.n;
      OP_BMI:  take = cc.n;
      OP_BHI:  take = !cc.c && !cc.z;
      OP_BLOS: take = cc.c || cc.z;
      OP_BVC:  take = !cc.v;
      OP_BVS:  take = cc.v;
      OP_BCC:  take = !cc.c;
      OP_BCS:  take = cc.c;
      default: ;
    endcase
    r.result_word  = w;
    r.write_back   = wb;
    r.flag_n       = f.n;
    r.flag_z       = f.z;
    r.flag_v       = f.v;
    r.flag_c       = f.c;
    r.branch_taken = take;
    r.next_pc      = take ? it.pc_value + {{7{it.br_disp[7]}}, it.br_disp, 1'b0}
                          : it.pc_value;
    return r;
  endfunction

  function automatic in_item_t make_op(logic [5:0] mode, logic [15:0] s, logic [15:0] d,
                                       logic [15:0] pc, logic [7:0] off);
    in_item_t it;
    it.mode     = mode;
    it.src_word = s;
    it.dst_word = d;
    it.pc_value = pc;
    it.br_disp  = off;
    return it;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return ALL_ONES;
      2:       return MAX_POS;
      3:       return SIGN_MASK;
      4:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_op(logic [5:0] mode);
    return make_op(mode, pick_word(), pick_word(), 16'($urandom), 8'($urandom_range(0, 255)));
  endfunction

  task automatic report_mismatch(string what);
    $display("tb_top: mismatch on result %0d: %s", checked_count, what);
    mismatch_count++;
  endtask

  // hold valid and payload until the transfer, then predict; gap only when idling is on
  task automatic send_op(in_item_t it);
    out_item_t e;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    e = alu_predict(it, cc_model);
    cc_model = {e.flag_n, e.flag_z, e.flag_v, e.flag_c};
    exp_results.push_back(e);
    sent_count++;
    if (tx_gap_en && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall     <= 1'b0;
      rx_burst_left <= 0;
    end else if (rx_hold_left > 0) begin
      out_stall    <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_burst_left > 0) begin
      out_stall     <= 1'b1;
      rx_burst_left <= rx_burst_left - 1;
    end else if (rx_gap_en && $urandom_range(0, 99) < 12) begin
      out_stall     <= 1'b1;
      rx_burst_left <= $urandom_range(0, 17);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        e = exp_results.pop_front();
        if (out_data.result_word !== e.result_word)
          report_mismatch($sformatf("result_word %h, want %h", out_data.result_word,
                                    e.result_word));
        if (out_data.write_back !== e.write_back)
          report_mismatch($sformatf("write_back %b, want %b", out_data.write_back,
                                    e.write_back));
        if (out_data.flag_n !== e.flag_n)
          report_mismatch($sformatf("flag_n %b, want %b", out_data.flag_n, e.flag_n));
        if (out_data.flag_z !== e.flag_z)
          report_mismatch($sformatf("flag_z %b, want %b", out_data.flag_z, e.flag_z));
        if (out_data.flag_v !== e.flag_v)
          report_mismatch($sformatf("flag_v %b, want %b", out_data.flag_v, e.flag_v));
        if (out_data.flag_c !== e.flag_c)
          report_mismatch($sformatf("flag_c %b, want %b", out_data.flag_c, e.flag_c));
        if (out_data.branch_taken !== e.branch_taken)
          report_mismatch($sformatf("branch_taken %b, want %b", out_data.branch_taken,
                                    e.branch_taken));
        if (out_data.next_pc !== e.next_pc)
          report_mismatch($sformatf("next_pc %h, want %h", out_data.next_pc, e.next_pc));
      end
      checked_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles, %0d results outstanding", cycle_count,
               exp_results.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic test_directed();
    send_op(make_op(OP_MOV,  SIGN_MASK, 16'h0000, 16'h0000, 8'h00));
    send_op(make_op(OP_CMP,  SIGN_MASK, 16'h0001, 16'h0100, 8'h00));
    send_op(make_op(OP_BIT,  ALL_ONES,  16'h0000, 16'h0200, 8'h00));
    send_op(make_op(OP_BIC,  ALL_ONES,  ALL_ONES, 16'h0300, 8'h00));
    send_op(make_op(OP_BIS,  16'h0000,  16'h0000, 16'h0400, 8'h00));
    send_op(make_op(OP_ADD,  MAX_POS,   16'h0001, 16'h0500, 8'h00));
    send_op(make_op(OP_ADD,  ALL_ONES,  ALL_ONES, 16'h0600, 8'h00));
    send_op(make_op(OP_SUB,  16'h0001,  SIGN_MASK, 16'h0700, 8'h00));
    send_op(make_op(OP_CLR,  ALL_ONES,  ALL_ONES, 16'h0800, 8'h00));
    send_op(make_op(OP_COM,  16'h0000,  16'h0000, 16'h0900, 8'h00));
    send_op(make_op(OP_ADC,  16'h0000,  ALL_ONES, 16'h0a00, 8'h00));
    send_op(make_op(OP_INC,  16'h0000,  MAX_POS,  16'h0b00, 8'h00));
    send_op(make_op(OP_DEC,  16'h0000,  SIGN_MASK, 16'h0c00, 8'h00));
    send_op(make_op(OP_NEG,  16'h0000,  SIGN_MASK, 16'h0d00, 8'h00));
    send_op(make_op(OP_NEG,  16'h0000,  16'h0000, 16'h0e00, 8'h00));
    send_op(make_op(OP_TST,  16'h0000,  ALL_ONES, 16'h0f00, 8'h00));
    send_op(make_op(OP_ROR,  16'h0000,  16'h0001, 16'h1000, 8'h00));
    send_op(make_op(OP_ROL,  16'h0000,  SIGN_MASK, 16'h1100, 8'h00));
    send_op(make_op(OP_ASR,  16'h0000,  16'h8001, 16'h1200, 8'h00));
    send_op(make_op(OP_ASL,  16'h0000,  16'h4000, 16'h1300, 8'h00));
    send_op(make_op(OP_SWAB, 16'h0000,  16'h00ff, 16'h1400, 8'h00));
    for (int m = OP_BR; m <= OP_BCS; m++)
      send_op(make_op(6'(m), pick_word(), pick_word(), (m % 2) ? ALL_ONES : 16'h0000,
                      (m % 2) ? 8'h7f : 8'h80));
    send_op(make_op(6'd34, ALL_ONES, ALL_ONES, 16'h1500, 8'hff));
    send_op(make_op(6'd63, ALL_ONES, ALL_ONES, ALL_ONES, 8'h80));
  endtask

  task automatic test_random_ops(int count);
    for (int i = 0; i < count; i++)
      if ($urandom_range(0, 99) < 90) send_op(random_op(6'($urandom_range(0, OP_BCS))));
      else send_op(random_op(6'($urandom_range(34, 63))));
  endtask

  // flag-setting operation followed by a branch (BR or a conditional one) on the flags it left
  task automatic test_flag_then_branch(int pairs);
    for (int i = 0; i < pairs; i++) begin
      send_op(random_op(6'($urandom_range(0, OP_SWAB))));
      send_op(random_op(6'($urandom_range(OP_BR, OP_BCS))));
    end
  endtask

  task automatic test_long_backpressure();
    tx_gap_en = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    rx_hold_left <= LONG_HOLD;
    test_random_ops(40);
    tx_gap_en = 1'b1;
  endtask

  task automatic test_steady_stream(int count);
    tx_gap_en = 1'b0;
    rx_gap_en = 1'b0;
    test_flag_then_branch(count / 2);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_ops(250);
    test_long_backpressure();
    wait_all_results();
    test_flag_then_branch(150);
    test_random_ops(150);
    wait_all_results();
    test_steady_stream(100);
    in_valid <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("tb_top: %0d operations sent, %0d results checked", sent_count, checked_count);
    $display("tb_top: covered all ALU and branch codes, unused codes, idling and backpressure");
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
